@@ src/brs_pkg.sv @@
// Shared types and constants for the beat repeat slicer.
// No dependencies; used by brs_fade and beat_repeat_slicer_unit.
`default_nettype none
package brs_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SLICE_W  = 16;

  localparam logic [SLICE_W-1:0] SLICE_LEN_RST = 16'd24000;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_RECORD = 2'd1,
    PH_LOOP   = 2'd2
  } phase_t;

  // per-stage advance enables for the gain pipeline
  typedef struct packed {
    logic prod;
    logic quot;
    logic outp;
  } brs_adv_t;

endpackage
`default_nettype wire

@@ src/brs_fade.sv @@
// Fade gain stage: sample * k / FADE_LEN, truncated toward zero, over three registers.
// Division by the constant uses a reciprocal multiply and a one-step correction.
// Depends on brs_pkg.
`default_nettype none
module brs_fade #(
  parameter int FADE_LEN = 100,
  localparam int KW = $clog2(FADE_LEN + 1)
) (
  input  wire logic                             clk,
  input  wire brs_pkg::brs_adv_t                adv,
  input  wire logic signed [brs_pkg::SAMPLE_W-1:0] sample_in,
  input  wire logic [KW-1:0]                    k_in,
  output logic signed [brs_pkg::SAMPLE_W-1:0]   sample_out
);

  localparam int SW = brs_pkg::SAMPLE_W;
  localparam int PW = SW + KW + 1;
  localparam int MW = SW + KW;
  localparam logic [MW:0]   RECIP = (MW + 1)'((64'd1 << MW) / FADE_LEN);
  localparam logic [MW-1:0] FQ    = MW'(FADE_LEN);

  logic signed [PW-1:0] prod_c;
  logic signed [PW-1:0] prod_r;
  logic                 neg_c;
  logic [PW-1:0]        abs_c;
  logic [MW-1:0]        mag_c;
  logic [2*MW:0]        rp_c;
  logic [MW-1:0]        q0_c;
  logic [MW-1:0]        q0_r;
  logic [MW-1:0]        mag_r;
  logic                 neg_r;
  logic [MW-1:0]        fq_c;
  logic [MW-1:0]        rem_c;
  logic [MW-1:0]        q_c;
  logic [MW-1:0]        qs_c;
  logic signed [SW-1:0] sample_out_r;

  always_comb begin
    prod_c = sample_in * $signed({1'b0, k_in});
  end

  always_comb begin
    neg_c = prod_r[PW-1];
    abs_c = neg_c ? (~prod_r + 1'b1) : prod_r;
    mag_c = abs_c[MW-1:0];
    rp_c  = mag_c * RECIP;
    q0_c  = rp_c[2*MW-1:MW];
  end

  // q0 is the true quotient or one below it
  always_comb begin
    fq_c  = q0_r * FQ;
    rem_c = mag_r - fq_c;
    q_c   = (rem_c >= FQ) ? (q0_r + 1'b1) : q0_r;
    qs_c  = neg_r ? (~q_c + 1'b1) : q_c;
  end

  always_ff @(posedge clk) begin
    if (adv.prod) begin
      prod_r <= prod_c;
    end
    if (adv.quot) begin
      q0_r  <= q0_c;
      mag_r <= mag_c;
      neg_r <= neg_c;
    end
    if (adv.outp) begin
      sample_out_r <= $signed(qs_c[SW-1:0]);
    end
  end

  assign sample_out = sample_out_r;

endmodule
`default_nettype wire

@@ src/beat_repeat_slicer_unit.sv @@
// Beat repeat slicer top level: trigger control, slice store and output pipeline.
// Depends on brs_pkg and brs_fade.
//
// Usage:
//   in_*  : one stereo sample per transaction, trigger and reverse in tuser.
//   out_* : one result per input transaction, in order; tuser flags looped output.
//   cfg_* : writes slice_length. Write only while no transaction is in flight.
// An accepted transaction moves through the v1, va, vb and ov registers to out_tvalid.
// Throughput: one transaction per cycle unless out_tready stalls or a rewrap runs.
//   Control state is updated at the accept edge; the slice store is one synchronous
//   RAM (one write, one read port), read for looping and written while recording,
//   never the same entry in one cycle.
// After a cfg transaction, cfg_ready and in_tready drop while the play position is
//   rewrapped against the new length by a one-bit-per-cycle remainder unit.
// Reset: pass-through, slice_length = 24000; store contents are undefined.
// When out_tready is low, the four pipeline stages fill up, then in_tready drops.
`default_nettype none
module beat_repeat_slicer_unit #(
  parameter int MAX_SLICE = 32768,
  parameter int FADE_LEN  = 100
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [15:0] left_in, [31:16] right_in
  input  wire logic [1:0]  in_tuser,   // [0] trigger, [1] reverse
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [15:0] left_out, [31:16] right_out
  output logic [0:0]       out_tuser,  // [0] looping
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data    // slice_length
);

  localparam int SW = brs_pkg::SAMPLE_W;
  localparam int AW = $clog2(MAX_SLICE);
  localparam int LW = $clog2(MAX_SLICE + 1);
  localparam int KW = $clog2(FADE_LEN + 1);
  localparam int CW = (LW > brs_pkg::SLICE_W) ? LW : brs_pkg::SLICE_W;
  localparam int XW = LW + KW;
  localparam int BW = $clog2(AW);

  // control state
  logic [brs_pkg::SLICE_W-1:0] slice_len_r;
  brs_pkg::phase_t             phase_r, phase_nxt, cur_phase;
  logic                        last_trig_r, last_trig_nxt;
  logic [LW-1:0]               fill_r, fill_nxt, cur_fill, fill_inc;
  logic [AW-1:0]               pos_r, pos_nxt;

  // rewrap unit
  logic                        busy_r;
  logic [BW-1:0]               bit_r;
  logic [LW-1:0]               rem_r;
  logic [LW:0]                 rem_shift, rem_step;

  // lengths and loop arithmetic
  logic [CW-1:0]               sl_ext;
  logic [LW-1:0]               eff_len, loop_len;
  logic [XW-1:0]               p_x, len_x;
  logic [KW-1:0]               loop_k;
  logic [AW-1:0]               loop_next_pos;
  logic                        rec_ok;

  // transaction fields
  logic                        in_fire, cfg_fire, trig, rev;

  // store
  logic [2*SW-1:0]             store_mem [MAX_SLICE];
  logic [2*SW-1:0]             mem_rd_r;
  logic                        mem_we, mem_re;
  logic [KW-1:0]               k_s0;
  logic                        loop_s0;

  // pipeline
  logic                        v1_r, loop1_r, va_r, loopa_r, vb_r, loopb_r, ov_r, loopo_r;
  logic [KW-1:0]               k1_r;
  logic [SW-1:0]               pass_l1_r, pass_r1_r;
  logic                        en_o, en_b, en_a, en_1;
  brs_pkg::brs_adv_t           adv;
  logic signed [SW-1:0]        sel_l, sel_r, res_l, res_r;

  assign trig     = in_tuser[0];
  assign rev      = in_tuser[1];
  assign in_fire  = in_tvalid && in_tready;
  assign cfg_fire = cfg_valid && cfg_ready;

  assign en_o = !ov_r || out_tready;
  assign en_b = !vb_r || en_o;
  assign en_a = !va_r || en_b;
  assign en_1 = !v1_r || en_a;

  assign in_tready = en_1 && !busy_r;
  assign cfg_ready = !busy_r;

  always_comb begin
    sl_ext = CW'(slice_len_r);
    if (sl_ext == '0) begin
      eff_len = LW'(1);
    end else if (sl_ext > CW'(MAX_SLICE)) begin
      eff_len = LW'(MAX_SLICE);
    end else begin
      eff_len = sl_ext[LW-1:0];
    end
    loop_len = (fill_r < eff_len) ? fill_r : eff_len;
    if (loop_len == '0) begin
      loop_len = LW'(1);
    end
  end

  // trigger edge handling
  always_comb begin
    cur_phase = phase_r;
    cur_fill  = fill_r;
    if (trig != last_trig_r) begin
      if (trig) begin
        cur_phase = brs_pkg::PH_RECORD;
        cur_fill  = '0;
      end else begin
        cur_phase = brs_pkg::PH_IDLE;
      end
    end
    rec_ok   = cur_fill < LW'(MAX_SLICE);
    fill_inc = cur_fill + LW'(1);
  end

  // fade gain and next play position; pos_r is always below loop_len here
  always_comb begin
    p_x   = XW'(pos_r);
    len_x = XW'(loop_len);
    if (p_x < XW'(FADE_LEN)) begin
      loop_k = KW'(pos_r);
    end else if (p_x + XW'(FADE_LEN) > len_x) begin
      loop_k = KW'(len_x - p_x - XW'(1));
    end else begin
      loop_k = KW'(FADE_LEN);
    end
    if (rev) begin
      loop_next_pos = (pos_r == '0) ? AW'(loop_len - LW'(1)) : (pos_r - 1'b1);
    end else begin
      loop_next_pos = (LW'(pos_r) + LW'(1) >= loop_len) ? '0 : (pos_r + 1'b1);
    end
  end

  // next state
  always_comb begin
    phase_nxt     = cur_phase;
    fill_nxt      = cur_fill;
    pos_nxt       = pos_r;
    last_trig_nxt = trig;
    unique case (cur_phase)
      brs_pkg::PH_IDLE: begin
      end
      brs_pkg::PH_RECORD: begin
        if (rec_ok) begin
          fill_nxt = fill_inc;
        end
        if ((rec_ok ? fill_inc : cur_fill) >= eff_len) begin
          phase_nxt = brs_pkg::PH_LOOP;
          pos_nxt   = '0;
        end
      end
      brs_pkg::PH_LOOP: begin
        pos_nxt = loop_next_pos;
      end
      default: begin
        phase_nxt = brs_pkg::PH_IDLE;
      end
    endcase
  end

  // store access and stage-one controls
  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    k_s0    = KW'(FADE_LEN);
    loop_s0 = 1'b0;
    unique case (cur_phase)
      brs_pkg::PH_IDLE: begin
      end
      brs_pkg::PH_RECORD: begin
        mem_we = in_fire && rec_ok;
      end
      brs_pkg::PH_LOOP: begin
        mem_re  = in_fire;
        k_s0    = loop_k;
        loop_s0 = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // rewrap: remainder of pos_r by loop_len, MSB first
  always_comb begin
    rem_shift = {rem_r, pos_r[bit_r]};
    rem_step  = (rem_shift >= {1'b0, loop_len}) ? (rem_shift - {1'b0, loop_len}) : rem_shift;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_len_r <= brs_pkg::SLICE_LEN_RST;
      phase_r     <= brs_pkg::PH_IDLE;
      last_trig_r <= 1'b0;
      fill_r      <= '0;
      pos_r       <= '0;
      busy_r      <= 1'b0;
      bit_r       <= '0;
      rem_r       <= '0;
    end else begin
      if (cfg_fire) begin
        slice_len_r <= cfg_data;
        busy_r      <= 1'b1;
        bit_r       <= BW'(AW - 1);
        rem_r       <= '0;
      end else if (busy_r) begin
        rem_r <= rem_step[LW-1:0];
        if (bit_r == '0) begin
          busy_r <= 1'b0;
          pos_r  <= rem_step[AW-1:0];
        end else begin
          bit_r <= bit_r - 1'b1;
        end
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        last_trig_r <= last_trig_nxt;
        fill_r      <= fill_nxt;
        pos_r       <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[cur_fill[AW-1:0]] <= in_tdata;
    end
    if (mem_re) begin
      mem_rd_r <= store_mem[pos_r];
    end
  end

  // pipeline valid and flag bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (en_1) begin
        v1_r <= in_fire;
      end
      if (en_a) begin
        va_r <= v1_r;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
      if (en_o) begin
        ov_r <= vb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      loop1_r   <= loop_s0;
      k1_r      <= k_s0;
      pass_l1_r <= in_tdata[SW-1:0];
      pass_r1_r <= in_tdata[2*SW-1:SW];
    end
    if (en_a) begin
      loopa_r <= loop1_r;
    end
    if (en_b) begin
      loopb_r <= loopa_r;
    end
    if (en_o) begin
      loopo_r <= loopb_r;
    end
  end

  assign sel_l = $signed(loop1_r ? mem_rd_r[SW-1:0] : pass_l1_r);
  assign sel_r = $signed(loop1_r ? mem_rd_r[2*SW-1:SW] : pass_r1_r);

  assign adv.prod = en_a;
  assign adv.quot = en_b;
  assign adv.outp = en_o;

  brs_fade #(
    .FADE_LEN (FADE_LEN)
  ) u_fade_l (
    .clk        (clk),
    .adv        (adv),
    .sample_in  (sel_l),
    .k_in       (k1_r),
    .sample_out (res_l)
  );

  brs_fade #(
    .FADE_LEN (FADE_LEN)
  ) u_fade_r (
    .clk        (clk),
    .adv        (adv),
    .sample_in  (sel_r),
    .k_in       (k1_r),
    .sample_out (res_r)
  );

  assign out_tvalid   = ov_r;
  assign out_tdata    = {res_r, res_l};
  assign out_tuser[0] = loopo_r;

endmodule
`default_nettype wire
